@@ rtl/ssp_mv_pkg.sv @@
// Package: shared constants and types for the sparse symmetric-profile mat-vec block.
package ssp_mv_pkg;
   localparam int MaxN       = 64;
   localparam int MaxEntries = 2048;
   localparam int NW         = $clog2(MaxN);
   localparam int EW         = $clog2(MaxEntries);
   localparam int RW         = 12;

   typedef enum logic [2:0] {
      ACT_DIAG   = 3'd0,
      ACT_ROW    = 3'd1,
      ACT_COL    = 3'd2,
      ACT_LOWER  = 3'd3,
      ACT_UPPER  = 3'd4,
      ACT_VECTOR = 3'd5,
      ACT_START  = 3'd6,
      ACT_NONE   = 3'd7
   } action_type;

   // Product of two Q16.16 values, floor-shifted back to Q16.16 (arithmetic shift = floor).
   function automatic logic signed [63:0] fix_shift(input logic signed [63:0] p);
      fix_shift = p >>> 16;
   endfunction

   // Saturating accumulate at +-2^62.
   function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                  input logic signed [63:0] b);
      logic signed [64:0] s;
      s = {a[63], a} + {b[63], b};
      if (s > 65'sd4611686018427387904)       sat_add = 64'sd4611686018427387904;
      else if (s < -65'sd4611686018427387904) sat_add = -64'sd4611686018427387904;
      else                                    sat_add = s[63:0];
   endfunction
endpackage

@@ rtl/sparse_symmetric_profile_matvec.sv @@
// Top level: sparse symmetric-profile matrix times vector, Q16.16, memory based.
// Load requests are accepted back to back while the block is idle.
// A start request runs a diagonal pass, reads each row's bounds and walks its stored entries
// (two accumulator read-modify-writes each, skipping out-of-range columns), then gives one
// result per row while the output is free; input is held off until the last result is loaded.
// Reset is synchronous, active high: sequencer and output stage clear, matrix_size becomes 1.
module sparse_symmetric_profile_matvec import ssp_mv_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // action[2:0], index[13:3], value[45:14], zero pad
   input  logic        rsp_tready,
   output logic        rsp_tvalid,
   output logic [39:0] rsp_tdata,   // row[5:0], result[37:6], zero pad
   output logic        rsp_tlast,   // last
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [6:0]  csr_data     // matrix_size
);
   typedef enum logic [11:0] {
      S_IDLE  = 12'h001, S_DRD = 12'h002, S_DWR = 12'h004, S_RLO = 12'h008,
      S_RHI   = 12'h010, S_ERD = 12'h020, S_EV  = 12'h040, S_LMUL = 12'h080,
      S_LWR   = 12'h100, S_UMUL = 12'h200, S_UWR = 12'h400, S_OUT = 12'h800
   } state_type;

   state_type            state_ff, state_in;
   logic [6:0]           size_ff;
   logic [NW-1:0]        n_last;
   logic [NW-1:0]        row_ff, row_in;
   logic [EW:0]          ent_ff, ent_in, hi_ff, hi_in;
   logic [1:0]           sub_ff, sub_in;
   logic signed [63:0]   prod_ff, prod_in;
   logic [NW-1:0]        col_ff, col_in;
   logic                 out_v_ff, out_v_in;
   logic [NW-1:0]        out_row_ff, out_row_in;
   logic [31:0]          out_res_ff, out_res_in;
   logic                 out_last_ff, out_last_in;

   action_type           act;
   logic [EW-1:0]        idx;
   logic [31:0]          val;
   logic                 acc_req;

   // One shared 32x32 signed multiplier; the sequencer picks its operands.
   logic signed [31:0]   mul_a, mul_b;
   logic signed [63:0]   mul_p;

   assign act = action_type'(req_tdata[2:0]);
   assign idx = req_tdata[13:3];
   assign val = req_tdata[45:14];
   assign acc_req = req_tvalid && req_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign csr_ready = 1'b1;
   assign mul_p = mul_a * mul_b;

   always_comb begin
      if (size_ff == 7'd0)         n_last = '0;
      else if (size_ff > 7'(MaxN)) n_last = NW'(MaxN - 1);
      else                         n_last = NW'(size_ff - 7'd1);
   end

   // Memories: small tables written by loads, read by the sequencer.
   logic [NW-1:0] nrd_addr, vrd_addr;
   logic [31:0]   diag_q, vec_q, low_q, up_q;
   logic [5:0]    col_q;
   logic [RW-1:0] rs_q;
   logic [6:0]    rs_addr;
   logic [EW-1:0] e_addr;
   logic          ld_idx_n, ld_idx_e;

   assign ld_idx_n = (idx[EW-1:NW] == '0);
   assign ld_idx_e = 1'b1;

   ssp_mv_mem #(.Width(32), .Depth(MaxN)) u_diag (
      .clock, .wr_en(acc_req && act == ACT_DIAG && ld_idx_n), .wr_addr(idx[NW-1:0]),
      .wr_data(val), .rd_addr(nrd_addr), .rd_data(diag_q));
   ssp_mv_mem #(.Width(32), .Depth(MaxN)) u_vec (
      .clock, .wr_en(acc_req && act == ACT_VECTOR && ld_idx_n), .wr_addr(idx[NW-1:0]),
      .wr_data(val), .rd_addr(vrd_addr), .rd_data(vec_q));
   ssp_mv_mem #(.Width(RW), .Depth(128)) u_rs (
      .clock, .wr_en(acc_req && act == ACT_ROW && idx <= EW'(MaxN)),
      .wr_addr(idx[6:0]), .wr_data(val[RW-1:0]), .rd_addr(rs_addr), .rd_data(rs_q));
   ssp_mv_mem #(.Width(6), .Depth(MaxEntries)) u_col (
      .clock, .wr_en(acc_req && act == ACT_COL && ld_idx_e), .wr_addr(idx),
      .wr_data(val[5:0]), .rd_addr(e_addr), .rd_data(col_q));
   ssp_mv_mem #(.Width(32), .Depth(MaxEntries)) u_low (
      .clock, .wr_en(acc_req && act == ACT_LOWER && ld_idx_e), .wr_addr(idx),
      .wr_data(val), .rd_addr(e_addr), .rd_data(low_q));
   ssp_mv_mem #(.Width(32), .Depth(MaxEntries)) u_up (
      .clock, .wr_en(acc_req && act == ACT_UPPER && ld_idx_e), .wr_addr(idx),
      .wr_data(val), .rd_addr(e_addr), .rd_data(up_q));

   // Accumulator RAM: one read and one write port; the sequencer never overlaps
   // a read with a pending write to the same row.
   logic          acc_we;
   logic [NW-1:0] acc_waddr, acc_raddr;
   logic [63:0]   acc_wdata, acc_q;

   ssp_mv_mem #(.Width(64), .Depth(MaxN)) u_acc (
      .clock, .wr_en(acc_we), .wr_addr(acc_waddr), .wr_data(acc_wdata),
      .rd_addr(acc_raddr), .rd_data(acc_q));

   logic [EW:0] rs_clamp;
   assign rs_clamp = (rs_q > RW'(MaxEntries)) ? (EW+1)'(MaxEntries) : (EW+1)'(rs_q);

   always_comb begin
      state_in = state_ff; row_in = row_ff; ent_in = ent_ff; hi_in = hi_ff;
      sub_in = sub_ff; prod_in = prod_ff; col_in = col_ff;
      out_v_in = out_v_ff; out_row_in = out_row_ff; out_res_in = out_res_ff;
      out_last_in = out_last_ff;
      nrd_addr = row_ff; vrd_addr = row_ff; rs_addr = {1'b0, row_ff};
      e_addr = ent_ff[EW-1:0]; acc_we = 1'b0; acc_waddr = row_ff;
      acc_wdata = prod_ff; acc_raddr = row_ff;
      mul_a = diag_q; mul_b = vec_q;
      if (rsp_tvalid && rsp_tready) out_v_in = 1'b0;
      case (state_ff)
         S_IDLE: begin
            row_in = '0;
            if (acc_req && act == ACT_START) state_in = S_DRD;
         end
         S_DRD: begin
            sub_in = sub_ff + 2'd1;
            if (sub_ff == 2'd1) begin
               prod_in = fix_shift(mul_p);
               sub_in = '0;
               state_in = S_DWR;
            end
         end
         S_DWR: begin
            acc_we = 1'b1;
            if (row_ff == n_last) begin
               row_in = '0; state_in = S_RLO;
            end else begin
               row_in = row_ff + 1'b1; state_in = S_DRD;
            end
         end
         S_RLO: begin
            sub_in = sub_ff + 2'd1;
            if (sub_ff == 2'd1) begin
               ent_in = rs_clamp; sub_in = '0; state_in = S_RHI;
            end
         end
         S_RHI: begin
            rs_addr = {1'b0, row_ff} + 7'd1;
            sub_in = sub_ff + 2'd1;
            if (sub_ff == 2'd1) begin
               hi_in = rs_clamp; sub_in = '0; state_in = S_ERD;
            end
         end
         S_ERD: begin
            if (ent_ff >= hi_ff) begin
               if (row_ff == n_last) begin
                  row_in = '0; state_in = S_OUT;
               end else begin
                  row_in = row_ff + 1'b1; state_in = S_RLO;
               end
            end else begin
               sub_in = sub_ff + 2'd1;
               if (sub_ff == 2'd1) begin
                  col_in = col_q; sub_in = '0;
                  state_in = (col_q > 6'(n_last)) ? S_EV : S_LMUL;
                  if (col_q > 6'(n_last)) ent_in = ent_ff + 1'b1;
               end
            end
         end
         S_EV: state_in = S_ERD;
         S_LMUL: begin
            vrd_addr = col_ff;
            mul_a = low_q;
            sub_in = sub_ff + 2'd1;
            if (sub_ff == 2'd1) prod_in = fix_shift(mul_p);
            if (sub_ff == 2'd2) begin
               prod_in = sat_add(acc_q, prod_ff); sub_in = '0; state_in = S_LWR;
            end
         end
         S_LWR: begin
            acc_we = 1'b1; state_in = S_UMUL;
         end
         S_UMUL: begin
            acc_raddr = col_ff;
            mul_a = up_q;
            sub_in = sub_ff + 2'd1;
            if (sub_ff == 2'd1) prod_in = fix_shift(mul_p);
            if (sub_ff == 2'd2) begin
               prod_in = sat_add(acc_q, prod_ff); sub_in = '0; state_in = S_UWR;
            end
         end
         S_UWR: begin
            acc_we = 1'b1; acc_waddr = col_ff;
            ent_in = ent_ff + 1'b1; state_in = S_ERD;
         end
         S_OUT: begin
            if (!out_v_ff || (rsp_tvalid && rsp_tready)) begin
               sub_in = sub_ff + 2'd1;
               if (sub_ff == 2'd1) begin
                  sub_in = '0;
                  out_v_in = 1'b1;
                  out_row_in = row_ff;
                  out_last_in = (row_ff == n_last);
                  if ($signed(acc_q) > 64'sd2147483647)       out_res_in = 32'h7fffffff;
                  else if ($signed(acc_q) < -64'sd2147483648) out_res_in = 32'h80000000;
                  else                                        out_res_in = acc_q[31:0];
                  if (row_ff == n_last) state_in = S_IDLE;
                  else row_in = row_ff + 1'b1;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         size_ff  <= 7'd1;
         out_v_ff <= 1'b0;
         sub_ff   <= '0;
         row_ff   <= '0;
      end else begin
         state_ff <= state_in;
         out_v_ff <= out_v_in;
         sub_ff   <= sub_in;
         row_ff   <= row_in;
         if (csr_valid && csr_ready) size_ff <= csr_data;
      end
      ent_ff <= ent_in; hi_ff <= hi_in; prod_ff <= prod_in; col_ff <= col_in;
      out_row_ff <= out_row_in; out_res_ff <= out_res_in; out_last_ff <= out_last_in;
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = {2'b00, out_res_ff, out_row_ff};
   assign rsp_tlast  = out_last_ff;
endmodule

@@ rtl/ssp_mv_mem.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
module ssp_mv_mem #(
   parameter int Width = 32,
   parameter int Depth = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
